FILE: src/hdt_pkg.sv
`timescale 1ns / 1ps

package hdt_pkg;

   localparam int NODE_COUNT    = 512;
   localparam int BITS_PER_ITEM = 8;

   localparam int NODE_AW = $clog2(NODE_COUNT);
   localparam int CNT_W   = $clog2(BITS_PER_ITEM + 1);
   localparam int PAD_W   = 8 - BITS_PER_ITEM;

   typedef enum logic {
      CMD_DECODE = 1'b0,
      CMD_LOAD   = 1'b1
   } cmd_type;

   typedef logic [8:0] node_idx_type;

   typedef struct packed {
      logic         leaf;
      logic [7:0]   symbol;
      node_idx_type left;
      node_idx_type right;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   function automatic logic node_ok(input node_idx_type idx);
      node_ok = (32'(idx) < NODE_COUNT);
   endfunction

endpackage

FILE: src/hdt_if.sv
`timescale 1ns / 1ps

interface hdt_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] code_byte;
   logic [8:0] node_index;
   logic       node_is_leaf;
   logic [7:0] node_symbol;
   logic [8:0] left_child;
   logic [8:0] right_child;

   modport source (
      output valid, cmd, code_byte, node_index, node_is_leaf, node_symbol,
             left_child, right_child,
      input  ready
   );
   modport sink (
      input  valid, cmd, code_byte, node_index, node_is_leaf, node_symbol,
             left_child, right_child,
      output ready
   );
endinterface

interface hdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, symbol, last, input ready);
   modport sink (input valid, symbol, last, output ready);
endinterface

interface hdt_csr_if;
   logic       valid;
   logic       ready;
   logic [8:0] root_node;

   modport source (output valid, root_node, input ready);
   modport sink (input valid, root_node, output ready);
endinterface

FILE: src/hdt_ram.sv
`timescale 1ns / 1ps

module hdt_ram #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 27
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/huffman_tree_bit_decoder_unit.sv
`timescale 1ns / 1ps

// Huffman tree-walk decoder. Load transactions (cmd=1) write one node of a 512-entry
// node table and return the walk to the root. Decode transactions (cmd=0) feed one
// code byte, MSB first; each leaf reached yields one symbol on rsp_chan, and the last
// symbol of a byte has last set. The walk position carries over between bytes.
// A decode keeps the block busy for one fetch of the walk node, a registered node read
// for each bit, one more fetch after every leaf except on the final bit, and a finish
// state, plus any rsp_chan stall; while the walk sits on a leaf root no child is read.
// The next transaction is accepted once the block is back in idle.
// req_chan is not ready while a byte is being decoded or while csr_chan.valid is high.
// Writing root_node also moves the walk to the new root. Node table contents are
// undefined until loaded.

module huffman_tree_bit_decoder_unit
   import hdt_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   hdt_req_if.sink   req_chan,
   hdt_rsp_if.source rsp_chan,
   hdt_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_STEP,
      S_CHILD,
      S_FINISH
   } state_type;

   state_type          state_ff;
   node_idx_type       root_ff;
   node_idx_type       walk_ff;
   node_idx_type       next_ff;
   logic [7:0]         shift_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               pend_valid_ff;
   logic [7:0]         pend_sym_ff;
   logic               out_valid_ff;
   logic [7:0]         out_sym_ff;
   logic               out_last_ff;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [NODE_AW-1:0] ram_rd_addr;
   logic [NODE_W-1:0]  ram_rd_data;
   node_type           wr_node;
   node_type           rd_node;
   node_idx_type       next_idx;
   logic               req_acc;
   logic               csr_acc;
   logic               out_free;
   logic               out_load;
   logic               last_bit;
   logic               root_stuck;

   assign csr_chan.ready = (state_ff == S_IDLE);
   assign req_chan.ready = (state_ff == S_IDLE) && !csr_chan.valid;
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign last_bit = (cnt_ff == CNT_W'(1));
   assign out_load = pend_valid_ff && out_free &&
                     (((state_ff == S_CHILD) && rd_node.leaf) || (state_ff == S_FINISH));

   assign rsp_chan.valid  = out_valid_ff;
   assign rsp_chan.symbol = out_sym_ff;
   assign rsp_chan.last   = out_last_ff;

   assign rd_node    = node_type'(ram_rd_data);
   assign next_idx   = shift_ff[7] ? rd_node.right : rd_node.left;
   assign root_stuck = (walk_ff == root_ff) && rd_node.leaf;

   always_comb begin
      wr_node.leaf   = req_chan.node_is_leaf;
      wr_node.symbol = req_chan.node_symbol;
      wr_node.left   = req_chan.left_child;
      wr_node.right  = req_chan.right_child;
      ram_wr_en      = req_acc && (req_chan.cmd == CMD_LOAD) && node_ok(req_chan.node_index);
      ram_rd_en      = 1'b0;
      ram_rd_addr    = NODE_AW'(walk_ff);
      unique case (state_ff)
         S_FETCH: begin
            ram_rd_en = node_ok(walk_ff);
         end
         S_STEP: begin
            if (!root_stuck && node_ok(next_idx)) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = NODE_AW'(next_idx);
            end
         end
         default: begin
         end
      endcase
   end

   hdt_ram #(
      .DEPTH (NODE_COUNT),
      .WIDTH (NODE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (NODE_AW'(req_chan.node_index)),
      .wr_data (NODE_W'(wr_node)),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         root_ff       <= '0;
         walk_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_chan.ready && !out_load) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (csr_acc) begin
                  root_ff <= csr_chan.root_node;
                  walk_ff <= csr_chan.root_node;
               end else if (req_acc) begin
                  if (req_chan.cmd == CMD_LOAD) begin
                     walk_ff <= root_ff;
                  end else begin
                     shift_ff <= req_chan.code_byte << PAD_W;
                     cnt_ff   <= CNT_W'(BITS_PER_ITEM);
                     state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               if (!node_ok(walk_ff)) begin
                  walk_ff  <= root_ff;
                  shift_ff <= shift_ff << 1;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
                  state_ff <= last_bit ? S_FINISH : S_FETCH;
               end else begin
                  state_ff <= S_STEP;
               end
            end
            S_STEP: begin
               if (root_stuck) begin
                  shift_ff <= shift_ff << 1;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
                  state_ff <= last_bit ? S_FINISH : S_STEP;
               end else if (!node_ok(next_idx)) begin
                  walk_ff  <= root_ff;
                  shift_ff <= shift_ff << 1;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
                  state_ff <= last_bit ? S_FINISH : S_FETCH;
               end else begin
                  next_ff  <= next_idx;
                  state_ff <= S_CHILD;
               end
            end
            S_CHILD: begin
               if (!rd_node.leaf) begin
                  walk_ff  <= next_ff;
                  shift_ff <= shift_ff << 1;
                  cnt_ff   <= cnt_ff - CNT_W'(1);
                  state_ff <= last_bit ? S_FINISH : S_STEP;
               end else if (!pend_valid_ff || out_free) begin
                  // hold the newest symbol back until we know whether it is the last
                  if (pend_valid_ff) begin
                     out_valid_ff <= 1'b1;
                     out_sym_ff   <= pend_sym_ff;
                     out_last_ff  <= 1'b0;
                  end
                  pend_valid_ff <= 1'b1;
                  pend_sym_ff   <= rd_node.symbol;
                  walk_ff       <= root_ff;
                  shift_ff      <= shift_ff << 1;
                  cnt_ff        <= cnt_ff - CNT_W'(1);
                  state_ff      <= last_bit ? S_FINISH : S_FETCH;
               end
            end
            S_FINISH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_sym_ff    <= pend_sym_ff;
                  out_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: src/hdt_checker.sv
`timescale 1ns / 1ps

module hdt_checker
   import hdt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_symbol,
   input logic       rsp_last,
   input logic       csr_valid,
   input logic       csr_ready
);

   // stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   // a decode transaction leaves the block busy: neither req nor csr is ready after it
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_DECODE) |=> !req_ready && !csr_ready)
      else $error("block ready right after a decode transaction");

   // a node load leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_LOAD) |=> csr_ready)
      else $error("block busy after a load transaction");

   // a root write leaves the block idle
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> csr_ready)
      else $error("block busy after a root write");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && csr_ready)
      else $error("block not idle after reset");

endmodule

bind huffman_tree_bit_decoder_unit hdt_checker u_hdt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_cmd    (req_chan.cmd),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_symbol (rsp_chan.symbol),
   .rsp_last   (rsp_chan.last),
   .csr_valid  (csr_chan.valid),
   .csr_ready  (csr_chan.ready)
);
